FILE: rtl/core/quaternion_rotation_alu_core_defines.svh
// Assertion macros for the quaternion rotation ALU core.
// Included by the RTL files that carry concurrent assertions; needs nothing else.
`ifndef QUATERNION_ROTATION_ALU_CORE_DEFINES_SVH
`define QUATERNION_ROTATION_ALU_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define QRALU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define QRALU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/qralu_pkg.sv
// Shared types and constants of the quaternion rotation ALU core.
// No dependencies; used by the channel interfaces and the core.
package qralu_pkg;

	localparam int unsigned COMPONENT_WIDTH_DEF = 16;
	localparam int unsigned OPCODE_WIDTH        = 3;
	localparam int unsigned TOL_WIDTH           = 15;
	localparam logic [TOL_WIDTH-1:0] TOL_RESET  = 15'd16;

	typedef enum logic [OPCODE_WIDTH-1:0] {
		OP_ADD    = 3'd0,
		OP_MUL_AB = 3'd1,
		OP_MUL_BA = 3'd2,
		OP_SCALE  = 3'd3,
		OP_CONJ   = 3'd4,
		OP_ROT    = 3'd5,
		OP_UNIT   = 3'd6
	} opcode_t;

endpackage

FILE: rtl/core/qralu_if.sv
// Valid/ready channel interfaces of the quaternion rotation ALU core.
// Depends on qralu_pkg for the opcode width and the default component width.

interface qralu_in_if #(
	parameter int unsigned COMPONENT_WIDTH = qralu_pkg::COMPONENT_WIDTH_DEF
);
	logic                                  valid;
	logic                                  ready;
	logic [qralu_pkg::OPCODE_WIDTH-1:0]    opcode;
	logic signed [COMPONENT_WIDTH-1:0]     a_x;
	logic signed [COMPONENT_WIDTH-1:0]     a_y;
	logic signed [COMPONENT_WIDTH-1:0]     a_z;
	logic signed [COMPONENT_WIDTH-1:0]     a_w;
	logic signed [COMPONENT_WIDTH-1:0]     b_x;
	logic signed [COMPONENT_WIDTH-1:0]     b_y;
	logic signed [COMPONENT_WIDTH-1:0]     b_z;
	logic signed [COMPONENT_WIDTH-1:0]     b_w;
	logic signed [COMPONENT_WIDTH-1:0]     scale_factor;

	modport source (
		output valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor,
		input  ready
	);
	modport sink (
		input  valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor,
		output ready
	);
endinterface

interface qralu_out_if #(
	parameter int unsigned COMPONENT_WIDTH = qralu_pkg::COMPONENT_WIDTH_DEF
);
	logic                              valid;
	logic                              ready;
	logic signed [COMPONENT_WIDTH-1:0] r_x;
	logic signed [COMPONENT_WIDTH-1:0] r_y;
	logic signed [COMPONENT_WIDTH-1:0] r_z;
	logic signed [COMPONENT_WIDTH-1:0] r_w;
	logic                              is_unit;
	logic                              overflow;

	modport source (
		output valid, r_x, r_y, r_z, r_w, is_unit, overflow,
		input  ready
	);
	modport sink (
		input  valid, r_x, r_y, r_z, r_w, is_unit, overflow,
		output ready
	);
endinterface

FILE: rtl/core/quaternion_rotation_alu_core.sv
// Quaternion rotation ALU core: four-stage pipeline of products, sums and saturation.
// Depends on qralu_pkg, qralu_if.sv and quaternion_rotation_alu_core_defines.svh.
//
// Usage
//   in_ch  : one word per item: opcode, quaternion A, quaternion B (or vector
//            x/y/z) and a scale factor, signed Q2.14 at the default width.
//   out_ch : one result word per item: r_x..r_w saturated, is_unit, overflow.
//   cfg_we / cfg_wdata : write of the unit-test tolerance; write only while
//            the pipeline is empty.
// Timing
//   Four register stages: s1 products, s2 sums and rotation coefficients,
//   s3 vector products, s4 final sums, saturation and the output register.
//   An accepted word passes s1, s2, s3 and s4 in turn before out_ch can take it.
//   One word per cycle sustained while out_ch takes each result; the rate is set by the
//   single shared stall enable of the four stages, which follows the output stage's ready.
// Reset
//   arst_n clears all stage valid bits and loads the tolerance with 16.
// Backpressure
//   When out_ch.ready is low with a word waiting in s4, every stage holds and
//   in_ch.ready drops in the same cycle; nothing is dropped or repeated.

`include "quaternion_rotation_alu_core_defines.svh"

module quaternion_rotation_alu_core #(
	parameter int unsigned COMPONENT_WIDTH = qralu_pkg::COMPONENT_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [qralu_pkg::TOL_WIDTH-1:0]    cfg_wdata,
	qralu_in_if.sink                           in_ch,
	qralu_out_if.source                        out_ch
);

	// ------------------------------------------------------------------
	// Widths. FRAC is the number of fraction bits (Q2.FRAC).
	// ------------------------------------------------------------------
	localparam int unsigned W    = COMPONENT_WIDTH;
	localparam int unsigned FRAC = W - 2;
	localparam int unsigned PW   = 2 * W;       // W x W product
	localparam int unsigned CW   = 2 * W + 2;   // rotation coefficient before shift
	localparam int unsigned MW   = CW - FRAC;   // coefficient after shift (W+4)
	localparam int unsigned RW   = MW + W;      // coefficient x vector product
	localparam int unsigned AW   = RW + 2;      // sum of three such products
	localparam int unsigned SW   = AW - FRAC;   // sum after the fraction shift
	localparam int unsigned UW   = (W + 2 > qralu_pkg::TOL_WIDTH + 1) ?
		W + 2 : qralu_pkg::TOL_WIDTH + 1;

	localparam logic signed [W-1:0]  COMP_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]  COMP_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [CW-1:0] ONE_SQ   = CW'(1) << (2 * FRAC);
	localparam logic signed [UW-1:0] ONE_U    = UW'(1) << FRAC;

	// indexes of the A x A products used by the rotation matrix
	localparam int unsigned AA_XX = 0;
	localparam int unsigned AA_YY = 1;
	localparam int unsigned AA_ZZ = 2;
	localparam int unsigned AA_XY = 3;
	localparam int unsigned AA_XZ = 4;
	localparam int unsigned AA_YZ = 5;
	localparam int unsigned AA_WX = 6;
	localparam int unsigned AA_WY = 7;
	localparam int unsigned AA_WZ = 8;

	// (one ? 1.0 : 0) +/- 2*t1 +/- 2*t2, exact, then shifted down by FRAC
	function automatic logic signed [MW-1:0] coef_f(
		input logic                 one,
		input logic signed [PW-1:0] t1,
		input logic                 neg1,
		input logic signed [PW-1:0] t2,
		input logic                 neg2
	);
		logic signed [CW-1:0] s;
		logic signed [CW-1:0] d1;
		logic signed [CW-1:0] d2;
		d1 = CW'(t1) <<< 1;
		d2 = CW'(t2) <<< 1;
		s  = one ? ONE_SQ : '0;
		s  = neg1 ? s - d1 : s + d1;
		s  = neg2 ? s - d2 : s + d2;
		return s[CW-1:FRAC];
	endfunction

	// ------------------------------------------------------------------
	// Tolerance register
	// ------------------------------------------------------------------
	logic [qralu_pkg::TOL_WIDTH-1:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= qralu_pkg::TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control: one enable for all stages
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en;

	assign en          = !vld_s4 || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_ch.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: all products, plus the cheap ops (add, conjugate, unit test)
	// ------------------------------------------------------------------
	logic signed [W-1:0]  a_c [4];
	logic signed [W-1:0]  b_c [4];

	assign a_c[0] = in_ch.a_x;
	assign a_c[1] = in_ch.a_y;
	assign a_c[2] = in_ch.a_z;
	assign a_c[3] = in_ch.a_w;
	assign b_c[0] = in_ch.b_x;
	assign b_c[1] = in_ch.b_y;
	assign b_c[2] = in_ch.b_z;
	assign b_c[3] = in_ch.b_w;

	logic signed [PW-1:0] pab_d  [4][4];
	logic signed [PW-1:0] paa_d  [9];
	logic signed [PW-1:0] psc_d  [4];
	logic signed [W-1:0]  lin_d  [4];
	logic                 lin_ovf_d;
	logic                 unit_d;

	logic signed [W:0]    ext_sum;
	logic [1:0]           ext_top;
	logic signed [UW-1:0] tol_s;
	logic signed [UW-1:0] dev;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				pab_d[i][j] = PW'(a_c[i]) * PW'(b_c[j]);
			end
			psc_d[i] = PW'(a_c[i]) * PW'(in_ch.scale_factor);
		end
		paa_d[AA_XX] = PW'(a_c[0]) * PW'(a_c[0]);
		paa_d[AA_YY] = PW'(a_c[1]) * PW'(a_c[1]);
		paa_d[AA_ZZ] = PW'(a_c[2]) * PW'(a_c[2]);
		paa_d[AA_XY] = PW'(a_c[0]) * PW'(a_c[1]);
		paa_d[AA_XZ] = PW'(a_c[0]) * PW'(a_c[2]);
		paa_d[AA_YZ] = PW'(a_c[1]) * PW'(a_c[2]);
		paa_d[AA_WX] = PW'(a_c[3]) * PW'(a_c[0]);
		paa_d[AA_WY] = PW'(a_c[3]) * PW'(a_c[1]);
		paa_d[AA_WZ] = PW'(a_c[3]) * PW'(a_c[2]);

		// add or conjugate, saturated; conjugate keeps w unchanged
		lin_ovf_d = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (in_ch.opcode == qralu_pkg::OP_CONJ) begin
				ext_sum = (i == 3) ? (W+1)'(a_c[i]) : -((W+1)'(a_c[i]));
			end else begin
				ext_sum = (W+1)'(a_c[i]) + (W+1)'(b_c[i]);
			end
			ext_top = ext_sum[W:W-1];
			if (ext_top == 2'b01) begin
				lin_d[i]  = COMP_MAX;
				lin_ovf_d = 1'b1;
			end else if (ext_top == 2'b10) begin
				lin_d[i]  = COMP_MIN;
				lin_ovf_d = 1'b1;
			end else begin
				lin_d[i] = ext_sum[W-1:0];
			end
		end

		// unit test: strict |dev| < tol on every component, w against 1.0
		tol_s  = $signed(UW'(tol_q));
		unit_d = 1'b1;
		for (int i = 0; i < 4; i++) begin
			dev = (i == 3) ? UW'(a_c[i]) - ONE_U : UW'(a_c[i]);
			if (!((dev < tol_s) && (dev > -tol_s))) begin
				unit_d = 1'b0;
			end
		end
	end

	logic [qralu_pkg::OPCODE_WIDTH-1:0] op_s1;
	logic signed [PW-1:0] pab_s1 [4][4];
	logic signed [PW-1:0] paa_s1 [9];
	logic signed [PW-1:0] psc_s1 [4];
	logic signed [W-1:0]  vec_s1 [3];
	logic signed [W-1:0]  lin_s1 [4];
	logic                 lin_ovf_s1;
	logic                 unit_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1      <= in_ch.opcode;
			pab_s1     <= pab_d;
			paa_s1     <= paa_d;
			psc_s1     <= psc_d;
			vec_s1[0]  <= b_c[0];
			vec_s1[1]  <= b_c[1];
			vec_s1[2]  <= b_c[2];
			lin_s1     <= lin_d;
			lin_ovf_s1 <= lin_ovf_d;
			unit_s1    <= unit_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: Hamilton / scale sums and the nine rotation coefficients
	// ------------------------------------------------------------------
	logic signed [AW-1:0] sum_d [4];
	logic signed [AW-1:0] sym   [3];
	logic signed [AW-1:0] crs   [3];
	logic signed [AW-1:0] dotw;
	logic signed [MW-1:0] m_d   [9];

	always_comb begin
		// A*B and B*A share the symmetric part; the cross part flips sign
		sym[0] = AW'(pab_s1[0][3]) + AW'(pab_s1[3][0]);
		crs[0] = AW'(pab_s1[1][2]) - AW'(pab_s1[2][1]);
		sym[1] = AW'(pab_s1[1][3]) + AW'(pab_s1[3][1]);
		crs[1] = AW'(pab_s1[2][0]) - AW'(pab_s1[0][2]);
		sym[2] = AW'(pab_s1[2][3]) + AW'(pab_s1[3][2]);
		crs[2] = AW'(pab_s1[0][1]) - AW'(pab_s1[1][0]);
		dotw   = AW'(pab_s1[3][3]) - AW'(pab_s1[0][0])
			- AW'(pab_s1[1][1]) - AW'(pab_s1[2][2]);

		unique case (op_s1)
			qralu_pkg::OP_MUL_AB: begin
				for (int i = 0; i < 3; i++) begin
					sum_d[i] = sym[i] + crs[i];
				end
				sum_d[3] = dotw;
			end
			qralu_pkg::OP_MUL_BA: begin
				for (int i = 0; i < 3; i++) begin
					sum_d[i] = sym[i] - crs[i];
				end
				sum_d[3] = dotw;
			end
			qralu_pkg::OP_SCALE: begin
				for (int i = 0; i < 4; i++) begin
					sum_d[i] = AW'(psc_s1[i]);
				end
			end
			default: begin
				for (int i = 0; i < 4; i++) begin
					sum_d[i] = '0;
				end
			end
		endcase

		m_d[0] = coef_f(1'b1, paa_s1[AA_YY], 1'b1, paa_s1[AA_ZZ], 1'b1);
		m_d[1] = coef_f(1'b0, paa_s1[AA_XY], 1'b0, paa_s1[AA_WZ], 1'b1);
		m_d[2] = coef_f(1'b0, paa_s1[AA_XZ], 1'b0, paa_s1[AA_WY], 1'b0);
		m_d[3] = coef_f(1'b0, paa_s1[AA_XY], 1'b0, paa_s1[AA_WZ], 1'b0);
		m_d[4] = coef_f(1'b1, paa_s1[AA_XX], 1'b1, paa_s1[AA_ZZ], 1'b1);
		m_d[5] = coef_f(1'b0, paa_s1[AA_YZ], 1'b0, paa_s1[AA_WX], 1'b1);
		m_d[6] = coef_f(1'b0, paa_s1[AA_XZ], 1'b0, paa_s1[AA_WY], 1'b1);
		m_d[7] = coef_f(1'b0, paa_s1[AA_YZ], 1'b0, paa_s1[AA_WX], 1'b0);
		m_d[8] = coef_f(1'b1, paa_s1[AA_XX], 1'b1, paa_s1[AA_YY], 1'b1);
	end

	logic [qralu_pkg::OPCODE_WIDTH-1:0] op_s2;
	logic signed [AW-1:0] sum_s2 [4];
	logic signed [MW-1:0] m_s2   [9];
	logic signed [W-1:0]  vec_s2 [3];
	logic signed [W-1:0]  lin_s2 [4];
	logic                 lin_ovf_s2;
	logic                 unit_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2      <= op_s1;
			sum_s2     <= sum_d;
			m_s2       <= m_d;
			vec_s2     <= vec_s1;
			lin_s2     <= lin_s1;
			lin_ovf_s2 <= lin_ovf_s1;
			unit_s2    <= unit_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: coefficient x vector products
	// ------------------------------------------------------------------
	logic signed [RW-1:0] prot_d [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prot_d[i][j] = RW'(m_s2[3*i+j]) * RW'(vec_s2[j]);
			end
		end
	end

	logic [qralu_pkg::OPCODE_WIDTH-1:0] op_s3;
	logic signed [AW-1:0] sum_s3  [4];
	logic signed [RW-1:0] prot_s3 [3][3];
	logic signed [W-1:0]  lin_s3  [4];
	logic                 lin_ovf_s3;
	logic                 unit_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3      <= op_s2;
			sum_s3     <= sum_s2;
			prot_s3    <= prot_d;
			lin_s3     <= lin_s2;
			lin_ovf_s3 <= lin_ovf_s2;
			unit_s3    <= unit_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: final sums, fraction shift, saturation, result select
	// ------------------------------------------------------------------
	logic signed [AW-1:0] acc    [4];
	logic signed [SW-1:0] shr    [4];
	logic [SW-W:0]        shr_top;
	logic signed [W-1:0]  sat_v  [4];
	logic [3:0]           sat_o;
	logic signed [W-1:0]  res_d  [4];
	logic                 ovf_d;
	logic                 is_unit_d;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (op_s3 == qralu_pkg::OP_ROT) begin
				acc[i] = (i == 3) ? '0 :
					AW'(prot_s3[i%3][0]) + AW'(prot_s3[i%3][1]) + AW'(prot_s3[i%3][2]);
			end else begin
				acc[i] = sum_s3[i];
			end
			shr[i]  = acc[i][AW-1:FRAC];
			shr_top = shr[i][SW-1:W-1];
			if ((&shr_top) || !(|shr_top)) begin
				sat_v[i] = shr[i][W-1:0];
				sat_o[i] = 1'b0;
			end else begin
				sat_v[i] = shr[i][SW-1] ? COMP_MIN : COMP_MAX;
				sat_o[i] = 1'b1;
			end
		end

		is_unit_d = 1'b0;
		unique case (op_s3)
			qralu_pkg::OP_ADD, qralu_pkg::OP_CONJ: begin
				res_d = lin_s3;
				ovf_d = lin_ovf_s3;
			end
			qralu_pkg::OP_MUL_AB, qralu_pkg::OP_MUL_BA, qralu_pkg::OP_SCALE: begin
				res_d = sat_v;
				ovf_d = |sat_o;
			end
			qralu_pkg::OP_ROT: begin
				res_d[0] = sat_v[0];
				res_d[1] = sat_v[1];
				res_d[2] = sat_v[2];
				res_d[3] = '0;
				ovf_d    = |sat_o[2:0];
			end
			qralu_pkg::OP_UNIT: begin
				for (int i = 0; i < 4; i++) begin
					res_d[i] = '0;
				end
				ovf_d     = 1'b0;
				is_unit_d = unit_s3;
			end
			default: begin
				// unused opcode: all-zero result word
				for (int i = 0; i < 4; i++) begin
					res_d[i] = '0;
				end
				ovf_d = 1'b0;
			end
		endcase
	end

	logic [qralu_pkg::OPCODE_WIDTH-1:0] op_s4;
	logic signed [W-1:0]  res_s4 [4];
	logic                 ovf_s4;
	logic                 is_unit_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s4      <= op_s3;
			res_s4     <= res_d;
			ovf_s4     <= ovf_d;
			is_unit_s4 <= is_unit_d;
		end
	end

	assign out_ch.valid    = vld_s4;
	assign out_ch.r_x      = res_s4[0];
	assign out_ch.r_y      = res_s4[1];
	assign out_ch.r_z      = res_s4[2];
	assign out_ch.r_w      = res_s4[3];
	assign out_ch.is_unit  = is_unit_s4;
	assign out_ch.overflow = ovf_s4;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`QRALU_ASSERT_NEXT(a_enter_s1, clk, arst_n, in_ch.valid && in_ch.ready, vld_s1, "accepted word did not reach s1")
	`QRALU_ASSERT_IMPL(a_unit_only, clk, arst_n, vld_s4 && is_unit_s4, op_s4 == qralu_pkg::OP_UNIT, "is_unit set outside unit test")
	`QRALU_ASSERT_IMPL(a_unit_zero, clk, arst_n, vld_s4 && (op_s4 == qralu_pkg::OP_UNIT), (res_s4[0] == '0) && (res_s4[1] == '0) && (res_s4[2] == '0) && (res_s4[3] == '0) && !ovf_s4, "unit test word not zero")
	`QRALU_ASSERT_IMPL(a_rot_w_zero, clk, arst_n, vld_s4 && (op_s4 == qralu_pkg::OP_ROT), res_s4[3] == '0, "rotation w not zero")
	`QRALU_ASSERT_IMPL(a_ovf_extreme, clk, arst_n, vld_s4 && ovf_s4, (res_s4[0] == COMP_MAX) || (res_s4[0] == COMP_MIN) || (res_s4[1] == COMP_MAX) || (res_s4[1] == COMP_MIN) || (res_s4[2] == COMP_MAX) || (res_s4[2] == COMP_MIN) || (res_s4[3] == COMP_MAX) || (res_s4[3] == COMP_MIN), "overflow without a saturated component")

endmodule

FILE: sim/quaternion_rotation_alu_core_test.sv
// Self-checking bench for quaternion_rotation_alu_core: a table of directed words, then
// random words at several tolerance settings; results checked by typed row or by predictor.
// Needs qralu_pkg, qralu_if.sv and the core RTL.
module quaternion_rotation_alu_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import qralu_pkg::*;

	localparam int CW           = COMPONENT_WIDTH_DEF;
	localparam int FRAC         = CW - 2;              // Q2.14 at the default width
	localparam int ONE          = 1 << FRAC;
	localparam int MAXV         = (1 << (CW - 1)) - 1;
	localparam int MINV         = -(1 << (CW - 1));
	localparam logic [OPCODE_WIDTH-1:0] OP_SPARE = 3'd7; // unused code, all-zero result
	localparam logic [TOL_WIDTH-1:0]    TOL_MAX  = '1;
	localparam int N_DIR        = 25;
	localparam int WORDS_TOTAL  = 1950;
	localparam int PHASES       = 6;
	localparam int HOLD_CYCLES  = 300;  // long receiver hold-off, fills the pipe
	localparam int IDLE_LIMIT   = 2000; // watchdog: cycles with no word moved
	localparam int DRAIN_CYCLES = 12;   // pipe is four deep, allow some margin

	typedef logic signed [CW-1:0] comp_t;
	typedef longint quad_t [4];

	typedef struct packed {
		logic [OPCODE_WIDTH-1:0] op;
		comp_t ax, ay, az, aw;
		comp_t bx, by, bz, bw;
		comp_t sc;
	} quat_word_t;

	typedef struct packed {
		comp_t rx, ry, rz, rw;
		logic  is_unit;
		logic  overflow;
	} quat_result_t;

	// one table row: operands, then a flag saying the result is typed in, then the result
	typedef struct packed {
		int op;
		int ax, ay, az, aw;
		int bx, by, bz, bw;
		int sc;
		int typed;
		int rx, ry, rz, rw;
		int is_unit, overflow;
	} dir_row_t;

	typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

	// Directed table. Rows with typed = 1 carry a result that is obvious by hand; the others
	// go through the predictor. The table runs at the reset tolerance of 16.
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		// unit test right at identity, and just inside the tolerance with junk in B
		'{OP_UNIT, 0, 0, 0, ONE, 0, 0, 0, 0, 0,
			1, 0, 0, 0, 0, 1, 0},
		'{OP_UNIT, -15, 15, 0, ONE + 15, MAXV, MINV, 7, -7, MAXV,
			1, 0, 0, 0, 0, 1, 0},
		// strict compare: off by exactly the tolerance fails
		'{OP_UNIT, 0, 0, 0, ONE - 16, 0, 0, 0, 0, 0,
			1, 0, 0, 0, 0, 0, 0},
		'{OP_UNIT, 16, 0, 0, ONE, 0, 0, 0, 0, 0,
			1, 0, 0, 0, 0, 0, 0},
		'{OP_UNIT, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV,
			1, 0, 0, 0, 0, 0, 0},
		'{OP_UNIT, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV,
			1, 0, 0, 0, 0, 0, 0},
		// add: saturation both ways, cancelling extremes, one lane clipping
		'{OP_ADD, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0,
			1, MAXV, MAXV, MAXV, MAXV, 0, 1},
		'{OP_ADD, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, 0,
			1, MINV, MINV, MINV, MINV, 0, 1},
		'{OP_ADD, MAXV, MINV, 1, -1, MINV, MAXV, -1, 1, 0,
			1, -1, -1, 0, 0, 0, 0},
		'{OP_ADD, 0, 0, 0, MINV, 0, 0, 0, -1, 0,
			1, 0, 0, 0, MINV, 0, 1},
		// conjugate: negating the most negative value clips; w passes untouched
		'{OP_CONJ, MINV, 5, MAXV, MINV, 0, 0, 0, 0, 0,
			1, MAXV, -5, -MAXV, MINV, 0, 1},
		'{OP_CONJ, 1, -2, 3, -4, 9, 9, 9, 9, 9,
			1, -1, 2, -3, -4, 0, 0},
		// products
		'{OP_MUL_AB, 0, 0, 0, ONE, 0, 0, 0, ONE, 0,
			1, 0, 0, 0, ONE, 0, 0},
		'{OP_MUL_AB, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, 0,
			0, 0, 0, 0, 0, 0, 0},
		'{OP_MUL_AB, MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV, MAXV, 0,
			0, 0, 0, 0, 0, 0, 0},
		'{OP_MUL_AB, ONE, 0, 0, 0, 0, ONE, 0, 0, 0,
			0, 0, 0, 0, 0, 0, 0},
		'{OP_MUL_BA, ONE, 0, 0, 0, 0, ONE, 0, 0, 0,
			0, 0, 0, 0, 0, 0, 0},
		'{OP_MUL_BA, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0,
			0, 0, 0, 0, 0, 0, 0},
		// scale: by 1.0 is exact, min*min clips, negative tiny product rounds down
		'{OP_SCALE, 100, -200, MAXV, MINV, 0, 0, 0, 0, ONE,
			1, 100, -200, MAXV, MINV, 0, 0},
		'{OP_SCALE, MINV, MINV, MAXV, 0, 0, 0, 0, 0, MINV,
			0, 0, 0, 0, 0, 0, 0},
		'{OP_SCALE, 1, -1, 3, -3, 0, 0, 0, 0, -1,
			0, 0, 0, 0, 0, 0, 0},
		// rotation: identity leaves the vector alone, w of B is ignored
		'{OP_ROT, 0, 0, 0, ONE, 1000, -2000, 3000, 77, 0,
			1, 1000, -2000, 3000, 0, 0, 0},
		// rotation by a far-from-unit quaternion saturates
		'{OP_ROT, MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, 0,
			0, 0, 0, 0, 0, 0, 0},
		// quarter turn about z
		'{OP_ROT, 0, 0, 11585, 11585, ONE, 0, 0, 0, 0,
			0, 0, 0, 0, 0, 0, 0},
		'{OP_SPARE, 1, 2, 3, 4, 5, 6, 7, 8, 9,
			1, 0, 0, 0, 0, 0, 0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [TOL_WIDTH-1:0] cfg_wdata;

	qralu_in_if  #(.COMPONENT_WIDTH(CW)) in_ch ();
	qralu_out_if #(.COMPONENT_WIDTH(CW)) out_ch ();

	quaternion_rotation_alu_core #(.COMPONENT_WIDTH(CW)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow of the tolerance register and the results still owed by the pipe
	logic [TOL_WIDTH-1:0] tol_shadow;
	quat_result_t         owed_results [$];

	// traffic shaping
	rx_mode_t rx_mode = RX_FREE;
	bit       hold_req = 1'b0;
	bit       tx_idle = 1'b0;
	int       burst_left = 0;

	int err_count = 0;
	int words_sent = 0;
	int results_seen = 0;
	int unit_hits = 0;
	int stall_cycles = 0;
	int tol_writes = 0;
	int quiet_cycles = 0;

	// ---------------------------------------------------------------- predictor

	function automatic longint clamp_comp(longint v);
		if (v > MAXV)
			return MAXV;
		if (v < MINV)
			return MINV;
		return v;
	endfunction

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Hamilton product p*q, order x y z w, already reduced to FRAC fraction bits
	function automatic quad_t hamilton_sums(quad_t p, quad_t q);
		quad_t s;
		s[0] = p[0] * q[3] + q[0] * p[3] + p[1] * q[2] - p[2] * q[1];
		s[1] = p[1] * q[3] + q[1] * p[3] + p[2] * q[0] - p[0] * q[2];
		s[2] = p[2] * q[3] + q[2] * p[3] + p[0] * q[1] - p[1] * q[0];
		s[3] = p[3] * q[3] - p[0] * q[0] - p[1] * q[1] - p[2] * q[2];
		for (int i = 0; i < 4; i++)
			s[i] = s[i] >>> FRAC;
		return s;
	endfunction

	function automatic quat_result_t predict_result(quat_word_t w,
			logic [TOL_WIDTH-1:0] tol);
		quad_t        a, b, s, r;
		longint       m [9];
		longint       one2, tl;
		quat_result_t res;
		a    = '{$signed(w.ax), $signed(w.ay), $signed(w.az), $signed(w.aw)};
		b    = '{$signed(w.bx), $signed(w.by), $signed(w.bz), $signed(w.bw)};
		s    = '{0, 0, 0, 0};
		res  = '0;
		one2 = longint'(ONE) * ONE;
		tl   = longint'(tol);
		case (w.op)
			OP_ADD: begin
				for (int i = 0; i < 4; i++)
					s[i] = a[i] + b[i];
			end
			OP_MUL_AB: s = hamilton_sums(a, b);
			OP_MUL_BA: s = hamilton_sums(b, a);
			OP_SCALE: begin
				for (int i = 0; i < 4; i++)
					s[i] = (a[i] * $signed(w.sc)) >>> FRAC;
			end
			OP_CONJ: s = '{-a[0], -a[1], -a[2], a[3]};
			OP_ROT: begin
				// rotation matrix of q v q*, coefficients cut to FRAC bits, no clipping
				m[0] = (one2 - a[1] * 2 * a[1] - a[2] * 2 * a[2]) >>> FRAC;
				m[1] = (a[0] * 2 * a[1] - a[3] * 2 * a[2]) >>> FRAC;
				m[2] = (a[0] * 2 * a[2] + a[3] * 2 * a[1]) >>> FRAC;
				m[3] = (a[0] * 2 * a[1] + a[3] * 2 * a[2]) >>> FRAC;
				m[4] = (one2 - a[0] * 2 * a[0] - a[2] * 2 * a[2]) >>> FRAC;
				m[5] = (a[1] * 2 * a[2] - a[3] * 2 * a[0]) >>> FRAC;
				m[6] = (a[0] * 2 * a[2] - a[3] * 2 * a[1]) >>> FRAC;
				m[7] = (a[1] * 2 * a[2] + a[3] * 2 * a[0]) >>> FRAC;
				m[8] = (one2 - a[0] * 2 * a[0] - a[1] * 2 * a[1]) >>> FRAC;
				for (int i = 0; i < 3; i++)
					s[i] = (m[3*i] * b[0] + m[3*i+1] * b[1] + m[3*i+2] * b[2]) >>> FRAC;
			end
			OP_UNIT: begin
				res.is_unit = (mag(a[3] - ONE) < tl) && (mag(a[0]) < tl) &&
					(mag(a[1]) < tl) && (mag(a[2]) < tl);
			end
			default: ;
		endcase
		for (int i = 0; i < 4; i++) begin
			r[i] = clamp_comp(s[i]);
			if (r[i] != s[i])
				res.overflow = 1'b1;
		end
		res.rx = r[0][CW-1:0];
		res.ry = r[1][CW-1:0];
		res.rz = r[2][CW-1:0];
		res.rw = r[3][CW-1:0];
		return res;
	endfunction

	// ---------------------------------------------------------------- stimulus

	// Mostly corner values and small numbers, the rest fully random bits.
	function automatic comp_t rand_comp();
		case ($urandom_range(0, 9))
			0: return comp_t'(MINV);
			1: return comp_t'(MAXV);
			2: return comp_t'(int'($urandom_range(0, 2)) - 1);
			3: return $urandom_range(0, 1) ? comp_t'(ONE) : comp_t'(-ONE);
			4, 5: return comp_t'(int'($urandom_range(0, 4000)) - 2000);
			default: return comp_t'($urandom);
		endcase
	endfunction

	function automatic comp_t near_comp(int center, int spread);
		int v;
		v = center + int'($urandom_range(0, 2 * spread)) - spread;
		return comp_t'(clamp_comp(v));
	endfunction

	function automatic quat_word_t random_word(logic [TOL_WIDTH-1:0] tol);
		quat_word_t w;
		real        q [4];
		real        norm;
		int         spread;
		w.op = OPCODE_WIDTH'($urandom_range(0, 6));
		w.ax = rand_comp();
		w.ay = rand_comp();
		w.az = rand_comp();
		w.aw = rand_comp();
		w.bx = rand_comp();
		w.by = rand_comp();
		w.bz = rand_comp();
		w.bw = rand_comp();
		w.sc = rand_comp();
		if (w.op == OP_ROT && $urandom_range(0, 9) < 6) begin
			// proper rotation: random direction on the unit 4-sphere
			norm = 0.0;
			for (int i = 0; i < 4; i++) begin
				q[i] = ($urandom_range(0, 20000) - 10000.0) / 10000.0;
				norm += q[i] * q[i];
			end
			norm = $sqrt(norm);
			if (norm > 1.0e-3) begin
				w.ax = comp_t'($rtoi(q[0] / norm * ONE));
				w.ay = comp_t'($rtoi(q[1] / norm * ONE));
				w.az = comp_t'($rtoi(q[2] / norm * ONE));
				w.aw = comp_t'($rtoi(q[3] / norm * ONE));
			end
		end else if (w.op == OP_UNIT && $urandom_range(0, 3) != 0) begin
			// straddle the tolerance edge around identity
			spread = int'(tol) + 2;
			w.ax = near_comp(0, spread);
			w.ay = near_comp(0, spread);
			w.az = near_comp(0, spread);
			w.aw = near_comp(ONE, spread);
		end
		return w;
	endfunction

	// Offer one word and hold it until taken. With tx_idle set the sender runs in bursts;
	// valid drops for a random gap. Ready is looked at on the falling edge, where it
	// has settled and holds until the rising edge that takes the word.
	task automatic send_word(quat_word_t w, quat_result_t r);
		int gap;
		bit took;
		if (tx_idle && burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 16) : $urandom_range(0, 3);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left != 0)
			burst_left--;
		in_ch.valid <= 1'b1;
		{in_ch.opcode, in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.a_w,
			in_ch.b_x, in_ch.b_y, in_ch.b_z, in_ch.b_w, in_ch.scale_factor} <= w;
		do begin
			@(negedge clk);
			took = in_ch.ready;
			@(posedge clk);
		end while (!took);
		owed_results.push_back(r);
		words_sent++;
	endtask

	// Tolerance writes only with the pipe empty: every word yields a result, so an
	// empty owed list at a rising edge means nothing is left inside.
	task automatic load_tolerance(logic [TOL_WIDTH-1:0] v);
		while (owed_results.size() != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		tol_shadow  = v;
		tol_writes++;
	endtask

	// ---------------------------------------------------------------- receiver

	// Ready follows the current pattern; a hold request drops it for a long stretch.
	initial begin
		int unsigned tick;
		tick         = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req <= 1'b0;
			end
			tick++;
			case (rx_mode)
				RX_FREE:   out_ch.ready <= 1'b1;
				RX_RANDOM: out_ch.ready <= ($urandom_range(0, 99) < 65);
				default:   out_ch.ready <= (tick % 7 != 3) && (tick % 13 != 0) &&
						(tick % 29 > 2);
			endcase
		end
	end

	// ---------------------------------------------------------------- checking

	task automatic check_field(string name, comp_t want_v, comp_t got_v);
		if (got_v !== want_v) begin
			err_count++;
			$display("t=%0t result %0d %s: expected %0d got %0d",
				$time, results_seen, name, want_v, got_v);
		end
	endtask

	// Output handshake seen on the falling edge before the taking rising edge.
	always @(negedge clk) begin
		quat_result_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.r_x, out_ch.r_y, out_ch.r_z, out_ch.r_w,
				out_ch.is_unit, out_ch.overflow};
			if (owed_results.size() == 0) begin
				err_count++;
				$display("t=%0t result word with nothing expected: %p", $time, got);
			end else begin
				want = owed_results.pop_front();
				check_field("r_x", want.rx, got.rx);
				check_field("r_y", want.ry, got.ry);
				check_field("r_z", want.rz, got.rz);
				check_field("r_w", want.rw, got.rw);
				check_field("is_unit", comp_t'(want.is_unit), comp_t'(got.is_unit));
				check_field("overflow", comp_t'(want.overflow), comp_t'(got.overflow));
				if (got.is_unit === 1'b1)
					unit_hits++;
			end
			results_seen++;
		end
	end

	// Watchdog: any word moving on either side restarts the count.
	always @(negedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (arst_n && in_ch.valid && !in_ch.ready)
			stall_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("t=%0t watchdog: nothing moved for %0d cycles, %0d results owed",
				$time, quiet_cycles, owed_results.size());
			$display("quaternion_rotation_alu_core_test: errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		dir_row_t             d;
		quat_word_t           w;
		quat_result_t         r;
		logic [TOL_WIDTH-1:0] tol_plan [PHASES];
		int                   per_phase;

		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		in_ch.valid = 1'b0;
		{in_ch.opcode, in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.a_w,
			in_ch.b_x, in_ch.b_y, in_ch.b_z, in_ch.b_w, in_ch.scale_factor} = '0;

		// extremes first, then 1, a couple of random settings and a mid value
		tol_plan[0] = '0;
		tol_plan[1] = TOL_MAX;
		tol_plan[2] = 15'd1;
		tol_plan[3] = TOL_WIDTH'($urandom_range(2, TOL_MAX - 1));
		tol_plan[4] = 15'd300;
		tol_plan[5] = TOL_WIDTH'($urandom_range(2, 64));
		per_phase   = (WORDS_TOTAL - N_DIR) / PHASES;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tol_shadow = TOL_RESET;

		// directed table at the reset tolerance, steady traffic
		for (int i = 0; i < N_DIR; i++) begin
			d      = DIR_ROWS[i];
			w.op   = d.op[OPCODE_WIDTH-1:0];
			w.ax   = comp_t'(d.ax);
			w.ay   = comp_t'(d.ay);
			w.az   = comp_t'(d.az);
			w.aw   = comp_t'(d.aw);
			w.bx   = comp_t'(d.bx);
			w.by   = comp_t'(d.by);
			w.bz   = comp_t'(d.bz);
			w.bw   = comp_t'(d.bw);
			w.sc   = comp_t'(d.sc);
			if (d.typed != 0) begin
				r = {comp_t'(d.rx), comp_t'(d.ry), comp_t'(d.rz), comp_t'(d.rw),
					d.is_unit[0], d.overflow[0]};
			end else begin
				r = predict_result(w, tol_shadow);
			end
			send_word(w, r);
		end
		in_ch.valid <= 1'b0;

		// random phases: each changes the tolerance and the traffic shape;
		// phases 1 and 4 also hold the receiver off long enough to back up the input
		for (int p = 0; p < PHASES; p++) begin
			load_tolerance(tol_plan[p]);
			rx_mode    <= rx_mode_t'(p % 3);
			tx_idle     = (p % 2 == 0) || (p == 5);
			burst_left  = 0;
			if (p % 3 == 1)
				hold_req <= 1'b1;
			repeat (per_phase) begin
				w = random_word(tol_shadow);
				send_word(w, predict_result(w, tol_shadow));
			end
			in_ch.valid <= 1'b0;
		end

		// drain, then give any stray extra word time to show up
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d words (%0d from the table) over %0d tolerance writes, %0d results",
			words_sent, N_DIR, tol_writes, results_seen);
		$display("run: %0d input stall cycles, %0d unit-test hits, %0d mismatches",
			stall_cycles, unit_hits, err_count);
		if (err_count == 0) begin
			$display("quaternion_rotation_alu_core_test: clean");
		end else begin
			$display("quaternion_rotation_alu_core_test: errors");
		end
		$finish;
	end

endmodule
